// ===== sv/lcsr_pkg.sv =====
package lcsr_pkg;

   localparam int RAW_W   = 24;
   localparam int FORCE_W = 24;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_TARE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd2;

   localparam logic [23:0]        TARE_RESET   = 24'd0;
   localparam logic [23:0]        SCALE_RESET  = 24'd65536;
   localparam logic signed [31:0] OFFSET_RESET = 32'sd0;

   // rounding bias for a q16 truncation toward zero
   localparam logic [48:0] MG_BIAS = 49'd65535;

   // below -150000 g a read is repeated once
   localparam logic signed [33:0] RETRY_LIMIT_MG = -34'sd150000000;

   // x / 1000 == (x >> 3) / 125, and (x >> 3) / 125 == (y * RECIP_125) >> RECIP_SHIFT
   // for every y below 2^30
   localparam logic [30:0] RECIP_125   = 31'd1099511628;
   localparam int          RECIP_SHIFT = 37;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH,
      PH_LOW,
      PH_XHIGH,
      PH_XLOW,
      PH_CALC
   } phase_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_MUL_LO,
      CS_MUL_HI,
      CS_SUM,
      CS_SCALE,
      CS_OFFSET,
      CS_SIGN,
      CS_RECIP,
      CS_DONE
   } calc_step_type;

   typedef enum logic {
      OP_TICK,
      OP_FINISH
   } op_kind_type;

   typedef struct packed {
      op_kind_type      kind;
      logic             sck;
      logic             busy;
      logic [RAW_W-1:0] raw;
      logic             retry_used;
   } op_type;

   typedef struct packed {
      logic valid;
      logic retry;
   } report_type;

   typedef struct packed {
      logic [23:0]        tare;
      logic [23:0]        scale;
      logic signed [31:0] offset;
   } cfg_type;

endpackage

// ===== sv/lcsr_front.sv =====
module lcsr_front #(
   parameter int DATA_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_start_req,
   input  logic                req_dout,
   input  logic                q_full,
   output logic                q_push,
   output lcsr_pkg::op_type    q_op,
   input  lcsr_pkg::report_type rpt
);
   import lcsr_pkg::*;

   localparam int CNT_W = $clog2(DATA_BITS + 1);

   phase_type            phase_ff, phase_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic                 ru_ff, ru_in;
   logic [DATA_BITS-1:0] flip_mask;
   logic                 req_fire;

   assign flip_mask = {1'b1, {(DATA_BITS-1){1'b0}}};
   assign req_stall = (phase_ff == PH_CALC) || q_full;
   assign req_fire  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         shift_ff <= '0;
         ru_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         ru_ff    <= ru_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      cnt_in          = cnt_ff;
      shift_in        = shift_ff;
      ru_in           = ru_ff;
      q_push          = 1'b0;
      q_op.kind       = OP_TICK;
      q_op.sck        = 1'b0;
      q_op.busy       = 1'b0;
      q_op.raw        = RAW_W'(shift_ff ^ flip_mask);
      q_op.retry_used = ru_ff;
      if (phase_ff == PH_CALC) begin
         // wait for the back end to decide on a repeat
         if (rpt.valid) begin
            phase_in = rpt.retry ? PH_WAIT : PH_IDLE;
            ru_in    = rpt.retry;
         end
      end else if (req_fire) begin
         q_push = 1'b1;
         unique case (phase_ff)
            PH_IDLE: begin
               if (req_start_req) begin
                  phase_in = PH_WAIT;
                  ru_in    = 1'b0;
               end
            end
            PH_WAIT: begin
               if (!req_dout) begin
                  phase_in = PH_HIGH;
                  cnt_in   = '0;
                  shift_in = '0;
               end
            end
            PH_HIGH: begin
               q_op.sck = 1'b1;
               phase_in = PH_LOW;
            end
            PH_LOW: begin
               shift_in = {shift_ff[DATA_BITS-2:0], req_dout};
               cnt_in   = cnt_ff + 1'b1;
               phase_in = (cnt_in == CNT_W'(DATA_BITS)) ? PH_XHIGH : PH_HIGH;
            end
            PH_XHIGH: begin
               q_op.sck = 1'b1;
               phase_in = PH_XLOW;
            end
            PH_XLOW: begin
               q_op.kind = OP_FINISH;
               phase_in  = PH_CALC;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         q_op.busy = (phase_in != PH_IDLE);
      end
   end

endmodule

// ===== sv/lcsr_queue.sv =====
module lcsr_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lcsr_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output lcsr_pkg::op_type head_op
);
   import lcsr_pkg::*;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   op_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== sv/lcsr_back.sv =====
module lcsr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lcsr_pkg::cfg_type             cfg,
   input  logic                          head_valid,
   input  lcsr_pkg::op_type              head_op,
   output logic                          q_pop,
   output lcsr_pkg::report_type          rpt,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_sck,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic [lcsr_pkg::RAW_W-1:0]    rsp_raw_count,
   output logic signed [lcsr_pkg::FORCE_W-1:0] rsp_force_grams,
   output logic                          rsp_was_retried
);
   import lcsr_pkg::*;

   calc_step_type      step_ff, step_in;
   logic               out_free, tick_load, fin_load, pop_finish;

   logic signed [24:0] diff_ff, diff_in;
   logic signed [12:0] mul_b;
   logic signed [37:0] mul_out;
   logic signed [37:0] plo_ff, phi_ff;
   logic signed [48:0] prod_ff, prod_in;
   logic [48:0]        bias_sum;
   logic [32:0]        mg_wide;
   logic signed [31:0] mg_ff, mg_in;
   logic signed [33:0] d_ff, d_in;
   logic [33:0]        d_abs;
   logic [29:0]        mag8_ff;
   logic               neg_ff, retry_ff, ru_ff;
   logic [60:0]        qprod_ff;
   logic [23:0]        quot;
   logic [FORCE_W-1:0] grams;
   logic [RAW_W-1:0]   raw_ff;

   logic [RAW_W-1:0]   last_raw_ff;
   logic [FORCE_W-1:0] last_force_ff;

   logic               rsp_valid_ff;
   logic               sck_ff, busy_ff, done_ff, retried_ff;
   logic [RAW_W-1:0]   raw_out_ff;
   logic [FORCE_W-1:0] force_out_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign q_pop      = head_valid && (step_ff == CS_IDLE) &&
                       ((head_op.kind == OP_FINISH) || out_free);
   assign tick_load  = q_pop && (head_op.kind == OP_TICK);
   assign pop_finish = q_pop && (head_op.kind == OP_FINISH);
   assign fin_load   = (step_ff == CS_DONE) && out_free;

   assign rpt.valid = fin_load;
   assign rpt.retry = retry_ff;

   // arithmetic datapath, one wide operation per step
   assign diff_in  = $signed({1'b0, head_op.raw}) - $signed({1'b0, cfg.tare});
   assign mul_b    = (step_ff == CS_MUL_LO) ? $signed({1'b0, cfg.scale[11:0]})
                                            : $signed({1'b0, cfg.scale[23:12]});
   assign mul_out  = diff_ff * mul_b;
   assign prod_in  = $signed(({{11{phi_ff[37]}}, phi_ff} << 12) +
                             {{11{plo_ff[37]}}, plo_ff});
   // truncate toward zero, then clamp to 32 bits
   assign bias_sum = prod_ff + (prod_ff[48] ? MG_BIAS : 49'd0);
   assign mg_wide  = bias_sum[48:16];
   assign mg_in    = (mg_wide[32] != mg_wide[31])
                     ? (mg_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                     : $signed(mg_wide[31:0]);
   assign d_in     = $signed({{2{mg_ff[31]}}, mg_ff}) -
                     $signed({{2{cfg.offset[31]}}, cfg.offset});
   assign d_abs    = d_ff[33] ? (34'd0 - d_ff) : d_ff;
   // magnitude stays below 2^23, so no clamp is needed on grams
   assign quot     = qprod_ff[60:RECIP_SHIFT];
   assign grams    = neg_ff ? (24'd0 - quot) : quot;

   always_comb begin
      step_in = step_ff;
      unique case (step_ff)
         CS_IDLE:   step_in = pop_finish ? CS_MUL_LO : CS_IDLE;
         CS_MUL_LO: step_in = CS_MUL_HI;
         CS_MUL_HI: step_in = CS_SUM;
         CS_SUM:    step_in = CS_SCALE;
         CS_SCALE:  step_in = CS_OFFSET;
         CS_OFFSET: step_in = CS_SIGN;
         CS_SIGN:   step_in = CS_RECIP;
         CS_RECIP:  step_in = CS_DONE;
         CS_DONE:   step_in = out_free ? CS_IDLE : CS_DONE;
         default:   step_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= CS_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_finish) begin
         diff_ff <= diff_in;
         raw_ff  <= head_op.raw;
         ru_ff   <= head_op.retry_used;
      end
      if (step_ff == CS_MUL_LO) plo_ff <= mul_out;
      if (step_ff == CS_MUL_HI) phi_ff <= mul_out;
      if (step_ff == CS_SUM)    prod_ff <= prod_in;
      if (step_ff == CS_SCALE)  mg_ff <= mg_in;
      if (step_ff == CS_OFFSET) d_ff <= d_in;
      if (step_ff == CS_SIGN) begin
         retry_ff <= (d_ff < RETRY_LIMIT_MG) && !ru_ff;
         neg_ff   <= d_ff[33];
         mag8_ff  <= d_abs[32:3];
      end
      if (step_ff == CS_RECIP)  qprod_ff <= mag8_ff * RECIP_125;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff   <= '0;
         last_force_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fin_load) begin
            last_raw_ff <= raw_ff;
            if (!retry_ff) begin
               last_force_ff <= grams;
            end
         end
         if (tick_load || fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_load) begin
         sck_ff       <= head_op.sck;
         busy_ff      <= head_op.busy;
         done_ff      <= 1'b0;
         retried_ff   <= 1'b0;
         raw_out_ff   <= last_raw_ff;
         force_out_ff <= last_force_ff;
      end else if (fin_load) begin
         sck_ff       <= 1'b0;
         busy_ff      <= retry_ff;
         done_ff      <= !retry_ff;
         retried_ff   <= !retry_ff && ru_ff;
         raw_out_ff   <= raw_ff;
         force_out_ff <= retry_ff ? last_force_ff : grams;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sck         = sck_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_was_retried = retried_ff;
   assign rsp_raw_count   = raw_out_ff;
   assign rsp_force_grams = $signed(force_out_ff);

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (step_ff == CS_DONE && !out_free) |=> (step_ff == CS_DONE))
      else $error("finished result dropped while output stalled");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_res) |-> !rsp_busy_res)
      else $error("done word still marked busy");

   a_retried_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_was_retried) |-> rsp_done_res)
      else $error("retried flag outside a done word");

endmodule

// ===== sv/load_cell_serial_reader_scaler.sv =====
// load cell serial reader and scaler
// req channel: one word per microsecond tick, carrying start_req and the
// converter's data line level. rsp channel: exactly one word per req word,
// in order, with the serial clock level for that tick, busy/done flags, the
// last offset-binary raw count and the last result in grams.
// csr port: write-only, index 0 tare count, 1 scale (q16 mg per count),
// 2 milligram offset; write only while no measurement is running.
// a front sequencer steps the serial timing, one req word per cycle while req
// is not stalled, and queues one command per tick; the back end turns each
// into a rsp word through a one-word output register.
// the tick that ends a read goes through the seven-step scaling sequence
// (two partial products, their sum, q16 truncation, offset, sign split,
// reciprocal divide by 1000), and req stalls from that tick until its
// result is out, plus the time to drain words queued ahead of it.
// a tick's rsp word passes through the queue and the output register; the
// word that ends a read also goes through the scaling steps.
// reset: sequencer idle, results zero, registers to their defaults.
// while rsp is stalled the queue keeps taking req words until it fills,
// then req stalls too; nothing is lost or repeated.
module load_cell_serial_reader_scaler #(
   parameter int DATA_BITS   = 24,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_start_req,
   input  logic                                 req_dout,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_sck,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic [lcsr_pkg::RAW_W-1:0]           rsp_raw_count,
   output logic signed [lcsr_pkg::FORCE_W-1:0]  rsp_force_grams,
   output logic                                 rsp_was_retried,
   input  logic                                 csr_wr_en,
   input  logic [lcsr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lcsr_pkg::CSR_W-1:0]           csr_wr_data
);
   import lcsr_pkg::*;

   cfg_type    cfg_ff;
   logic       q_push, q_full, q_pop, head_valid;
   op_type     push_op, head_op;
   report_type rpt;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tare   <= TARE_RESET;
         cfg_ff.scale  <= SCALE_RESET;
         cfg_ff.offset <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARE:   cfg_ff.tare   <= csr_wr_data[23:0];
            CSR_SCALE:  cfg_ff.scale  <= csr_wr_data[23:0];
            CSR_OFFSET: cfg_ff.offset <= $signed(csr_wr_data);
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   lcsr_front #(
      .DATA_BITS (DATA_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .req_dout      (req_dout),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_op          (push_op),
      .rpt           (rpt)
   );

   lcsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   lcsr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (head_valid),
      .head_op         (head_op),
      .q_pop           (q_pop),
      .rpt             (rpt),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sck         (rsp_sck),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_raw_count   (rsp_raw_count),
      .rsp_force_grams (rsp_force_grams),
      .rsp_was_retried (rsp_was_retried)
   );

endmodule
